// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the RTL of the windowed overlap-add stream unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AST_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define AST_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== hw/rtl/woas_pkg.sv =====
// Package with register codes, curve codes and the curve coefficient function.
`timescale 1ns / 1ps
package woas_pkg;

   localparam logic [1:0] REG_FRAME_SIZE_LOG2 = 2'd0;
   localparam logic [1:0] REG_SHAPE_SELECT    = 2'd1;
   localparam logic [1:0] REG_ACCUMULATE_MODE = 2'd2;

   localparam logic [2:0] SHAPE_SQRT     = 3'd0;
   localparam logic [2:0] SHAPE_SQUARE   = 3'd1;
   localparam logic [2:0] SHAPE_LINEAR   = 3'd2;
   localparam logic [2:0] SHAPE_RAISED   = 3'd3;
   localparam logic [2:0] SHAPE_SQUARED  = 3'd4;

   localparam logic [63:0] Q30    = 64'd1073741824;
   localparam logic [63:0] PI_Q30 = 64'd3373259426;

   function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
      logic [63:0] n;
      logic [63:0] r;
      logic [63:0] b;
      int i;
      n = n_in;
      r = 64'd0;
      b = 64'd1 << 62;
      for (i = 0; i < 32; i++) begin
         if (b > n) begin
            b = b >> 2;
         end
      end
      for (i = 0; i < 32; i++) begin
         if (b != 64'd0) begin
            if (n >= r + b) begin
               n = n - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
      end
      return r;
   endfunction

   function automatic logic [63:0] taylor_div(input logic [63:0] v, input int k);
      logic [63:0] q;
      case (k)
         1:       q = v / 64'd2;
         2:       q = v / 64'd12;
         3:       q = v / 64'd30;
         4:       q = v / 64'd56;
         5:       q = v / 64'd90;
         6:       q = v / 64'd132;
         7:       q = v / 64'd182;
         default: q = v / 64'd240;
      endcase
      return q;
   endfunction

   function automatic logic [63:0] raised_cos_q30(input logic [63:0] x, input int coef_bits);
      logic [63:0] f;
      logic        upper;
      logic [63:0] xr;
      logic [63:0] th;
      logic [63:0] th2;
      logic [63:0] term;
      logic signed [63:0] c;
      int k;
      f = 64'd1 << coef_bits;
      upper = (x > (f >> 1));
      xr = upper ? (f - x) : x;
      th = (PI_Q30 * xr) >> coef_bits;
      th2 = (th * th) >> 30;
      term = Q30;
      c = $signed(Q30);
      for (k = 1; k <= 8; k++) begin
         term = taylor_div((term * th2) >> 30, k);
         if ((k % 2) == 1) begin
            c = c - $signed(term);
         end else begin
            c = c + $signed(term);
         end
      end
      if (c < 0) begin
         c = 64'sd0;
      end
      if (upper) begin
         c = -c;
      end
      return $unsigned($signed(Q30) - c) >> 1;
   endfunction

   function automatic logic [63:0] q30_to_coef(input logic [63:0] v, input int coef_bits);
      return (v + (64'd1 << (29 - coef_bits))) >> (30 - coef_bits);
   endfunction

   function automatic logic [63:0] coef_value(input logic [2:0] shape, input logic [63:0] x,
                                              input int coef_bits);
      logic [63:0] f;
      logic [63:0] p;
      logic [63:0] r;
      f = 64'd1 << coef_bits;
      case (shape)
         SHAPE_SQRT:   p = isqrt64(x * f);
         SHAPE_SQUARE: p = (x * x + (f >> 1)) >> coef_bits;
         SHAPE_LINEAR: p = x;
         SHAPE_RAISED: p = q30_to_coef(raised_cos_q30(x, coef_bits), coef_bits);
         default: begin
            r = raised_cos_q30(x, coef_bits);
            p = q30_to_coef((r * r) >> 30, coef_bits);
         end
      endcase
      if (p > f - 64'd1) begin
         p = f - 64'd1;
      end
      return p;
   endfunction

endpackage

// ===== hw/rtl/windowed_overlap_add_stream_unit.sv =====
// Windowed overlap-add stream unit: crossfade windowing of a delayed sample stream.
//
// The req channel carries one input sample and the present output sample per transfer;
// the rsp channel returns one windowed sample per accepted input, delayed by one frame.
// The window sum is silence for the first frame after reset or a frame size write.
// An input is accepted only while the unit is idle, so a new input waits until the
// previous one has passed every step: registered memory read, first multiply, second
// multiply, sum and saturation, then output. A result waits in the output register;
// the next input is accepted while it waits, and the unit holds its finished sample in
// the last step only while the previous result is still not taken.
// The frame memory holds the last frame of samples and is read before it is overwritten
// at the same position, so no clearing pass is needed: the silence counter masks it.
// Curve coefficients come from a constant table built at elaboration. The curve in use
// is taken at each half-frame boundary, one for the fade-in and one for the tail.
// Reset restores frame_size_log2 = 9, the square-root curve and replace mode.
// A write to frame_size_log2 restarts the position and silence counters.
// Configuration is written over the csr APB-style port; pready is always high.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module windowed_overlap_add_stream_unit #(
   parameter int MAX_FRAME   = 1024,
   parameter int SAMPLE_BITS = 24,
   parameter int COEF_BITS   = 16
) (
   input  logic                                     clock,
   input  logic                                     reset,
   // sample_in, existing_out
   input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]       req_tdata,
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   // sample_out
   output logic [((SAMPLE_BITS+7)/8)*8-1:0]         rsp_tdata,
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   input  logic                                     csr_psel,
   input  logic                                     csr_penable,
   input  logic                                     csr_pwrite,
   input  logic [3:0]                               csr_paddr,
   input  logic [31:0]                              csr_pwdata,
   output logic [31:0]                              csr_prdata,
   output logic                                     csr_pready
);

   localparam int SB    = SAMPLE_BITS;
   localparam int RSW   = ((SAMPLE_BITS+7)/8)*8;
   localparam int AW    = $clog2(MAX_FRAME);
   localparam int LMAX  = (AW < 10) ? AW : 10;
   localparam int HMAX  = LMAX - 1;
   localparam int TDEP  = 5 << HMAX;
   localparam int TAW   = $clog2(TDEP);
   localparam int PW    = SAMPLE_BITS + COEF_BITS + 2;
   localparam int CW    = AW + 1;

   localparam logic signed [PW-1:0] RND_HALF = PW'(64'd1 << (COEF_BITS - 1));
   localparam logic signed [PW-1:0] SAT_HI   = PW'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
   localparam logic signed [PW-1:0] SAT_LO   = -SAT_HI - PW'(1);
   localparam logic [COEF_BITS:0]   COEF_ONE = (COEF_BITS+1)'(64'd1 << COEF_BITS);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL1 = 3'd1;
   localparam logic [2:0] ST_MUL2 = 3'd2;
   localparam logic [2:0] ST_SUM  = 3'd3;
   localparam logic [2:0] ST_OUT  = 3'd4;

   typedef logic [COEF_BITS-1:0] coef_table_type [TDEP];

   function automatic coef_table_type build_table();
      coef_table_type t;
      logic [63:0]    x;
      int             s;
      int             z;
      for (s = 0; s < 5; s++) begin
         for (z = 0; z < (1 << HMAX); z++) begin
            if (COEF_BITS >= HMAX) begin
               x = 64'(z) << (COEF_BITS - HMAX);
            end else begin
               x = 64'(z) >> (HMAX - COEF_BITS);
            end
            t[s * (1 << HMAX) + z] = COEF_BITS'(woas_pkg::coef_value(3'(s), x, COEF_BITS));
         end
      end
      return t;
   endfunction

   localparam coef_table_type COEF_TABLE = build_table();

   function automatic logic signed [PW-1:0] sat_fn(input logic signed [PW-1:0] v);
      logic signed [PW-1:0] r;
      if (v > SAT_HI) begin
         r = SAT_HI;
      end else if (v < SAT_LO) begin
         r = SAT_LO;
      end else begin
         r = v;
      end
      return r;
   endfunction

   logic [3:0]  size_raw_ff;
   logic [3:0]  size_log2_ff;
   logic [2:0]  shape_ff;
   logic        accum_ff;
   logic [2:0]  shape_cur_ff;
   logic [2:0]  shape_prev_ff;
   logic [2:0]  state_ff;
   logic [2:0]  state_in;
   logic [AW-1:0] pos_ff;
   logic [CW-1:0] cnt_ff;
   logic [SB-1:0] sample_ff;
   logic [SB-1:0] exist_ff;
   logic [SB-1:0] old_ff;
   logic [COEF_BITS-1:0] coef_ff;
   logic [COEF_BITS-1:0] coef_tail_ff;
   logic signed [PW-1:0] prod1_ff;
   logic signed [PW-1:0] prod2_ff;
   logic signed [PW-1:0] y_ff;
   logic [SB-1:0] rsp_data_ff;
   logic          rsp_valid_ff;

   logic          req_fire;
   logic          csr_write;
   logic          size_write;
   logic [3:0]    size_wr_val;
   logic [CW-1:0] frame_len;
   logic [AW-1:0] half_mask;
   logic [3:0]    half_log2;
   logic [AW-1:0] z_full;
   logic [2:0]    shape_eff;
   logic [2:0]    table_shape;
   logic [TAW-1:0] table_idx;
   logic [COEF_BITS-1:0] coef_lookup;
   logic          frame_step;
   logic [SB-1:0] mem_rd_data;
   logic [COEF_BITS:0] coef_inv;
   logic signed [PW-1:0] round1;
   logic signed [PW-1:0] round2;
   logic signed [PW-1:0] tail_val;
   logic signed [PW-1:0] y_val;
   logic signed [PW-1:0] out_val;
   logic          out_free;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign size_write = csr_write && (csr_paddr[3:2] == woas_pkg::REG_FRAME_SIZE_LOG2);
   assign size_wr_val = (csr_pwdata[3:0] < 4'd4) ? 4'd4 :
                        (csr_pwdata[3:0] > 4'(LMAX)) ? 4'(LMAX) : csr_pwdata[3:0];

   always_comb begin
      case (csr_paddr[3:2])
         woas_pkg::REG_FRAME_SIZE_LOG2: csr_prdata = {28'd0, size_raw_ff};
         woas_pkg::REG_SHAPE_SELECT:    csr_prdata = {29'd0, shape_ff};
         woas_pkg::REG_ACCUMULATE_MODE: csr_prdata = {31'd0, accum_ff};
         default:                       csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_raw_ff  <= 4'd9;
         size_log2_ff <= (4'd9 > 4'(LMAX)) ? 4'(LMAX) : 4'd9;
         shape_ff     <= woas_pkg::SHAPE_SQRT;
         accum_ff     <= 1'b0;
      end else if (csr_write) begin
         case (csr_paddr[3:2])
            woas_pkg::REG_FRAME_SIZE_LOG2: begin
               size_raw_ff  <= csr_pwdata[3:0];
               size_log2_ff <= size_wr_val;
            end
            woas_pkg::REG_SHAPE_SELECT:    shape_ff <= csr_pwdata[2:0];
            woas_pkg::REG_ACCUMULATE_MODE: accum_ff <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   assign frame_len = CW'(1) << size_log2_ff;
   assign half_log2 = size_log2_ff - 4'd1;
   assign half_mask = AW'((CW'(1) << half_log2) - CW'(1));
   assign z_full    = (pos_ff & half_mask) << (4'(HMAX) - half_log2);
   assign shape_eff = (shape_ff > woas_pkg::SHAPE_SQUARED) ? woas_pkg::SHAPE_SQUARED : shape_ff;
   assign table_shape = (state_ff == ST_IDLE) ? shape_cur_ff : shape_prev_ff;
   assign table_idx = TAW'(table_shape) * TAW'(1 << HMAX) + TAW'(z_full);
   assign coef_lookup = COEF_TABLE[table_idx];
   assign frame_step = ((pos_ff & half_mask) == half_mask) && (cnt_ff >= frame_len - CW'(1));

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid & req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   woas_ram #(
      .WIDTH(SB),
      .DEPTH(MAX_FRAME)
   ) u_frame_ram (
      .clock  (clock),
      .wr_en  (state_ff == ST_MUL1),
      .wr_addr(pos_ff),
      .wr_data(sample_ff),
      .rd_en  (req_fire),
      .rd_addr(pos_ff),
      .rd_data(mem_rd_data)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_fire) state_in = ST_MUL1;
         ST_MUL1: state_in = ST_MUL2;
         ST_MUL2: state_in = ST_SUM;
         ST_SUM:  state_in = ST_OUT;
         ST_OUT:  if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   assign coef_inv = COEF_ONE - {1'b0, coef_tail_ff};
   assign round1   = (prod1_ff + RND_HALF) >>> COEF_BITS;
   assign round2   = (prod2_ff + RND_HALF) >>> COEF_BITS;
   assign tail_val = (cnt_ff >= frame_len + (frame_len >> 1)) ? sat_fn(round2) : '0;
   assign y_val    = (cnt_ff >= frame_len) ? sat_fn(round1 + tail_val) : '0;
   assign out_val  = accum_ff ? sat_fn(y_ff + PW'($signed(exist_ff))) : y_ff;

   always_ff @(posedge clock) begin
      if (req_fire) begin
         sample_ff <= req_tdata[SB-1:0];
         exist_ff  <= req_tdata[2*SB-1:SB];
         coef_ff   <= coef_lookup;
      end
      if (state_ff == ST_MUL1) begin
         old_ff       <= mem_rd_data;
         coef_tail_ff <= coef_lookup;
         prod1_ff     <= PW'($signed(mem_rd_data)) * PW'($signed({1'b0, coef_ff}));
      end
      if (state_ff == ST_MUL2) begin
         prod2_ff <= PW'($signed(old_ff)) * PW'($signed({1'b0, coef_inv}));
      end
      if (state_ff == ST_SUM) begin
         y_ff <= y_val;
      end
      if ((state_ff == ST_OUT) && out_free) begin
         rsp_data_ff <= out_val[SB-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pos_ff        <= '0;
         cnt_ff        <= '0;
         shape_cur_ff  <= woas_pkg::SHAPE_SQRT;
         shape_prev_ff <= woas_pkg::SHAPE_SQRT;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (size_write) begin
            pos_ff <= '0;
            cnt_ff <= '0;
         end else if ((state_ff == ST_OUT) && out_free) begin
            pos_ff <= (CW'(pos_ff) == frame_len - CW'(1)) ? '0 : pos_ff + AW'(1);
            if (cnt_ff < frame_len + (frame_len >> 1)) begin
               cnt_ff <= cnt_ff + CW'(1);
            end
            if (frame_step) begin
               shape_prev_ff <= shape_cur_ff;
               shape_cur_ff  <= shape_eff;
            end
         end
         if ((state_ff == ST_OUT) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSW'(rsp_data_ff);

   `AST_NEXT(a_busy_after_accept, clock, reset, req_fire, !req_tready)
   `AST_SAME(a_pos_in_frame, clock, reset, 1'b1, CW'(pos_ff) < frame_len)
   `AST_NEXT(a_size_restarts, clock, reset, size_write, (pos_ff == '0) && (cnt_ff == '0))

endmodule

// ===== hw/rtl/woas_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps
module woas_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
